### rtl/core/sv39ptw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sv39ptw_pkg;

	localparam int PPN_W  = 44;
	localparam int PA_W   = 56;
	localparam int VA_W   = 39;
	localparam int PTE_W  = 64;
	localparam int VPN_W  = 9;
	localparam int IDX_W  = 12;
	localparam int ENTRIES_PER_TABLE = 512;

	localparam logic CMD_WRITE     = 1'b0;
	localparam logic CMD_TRANSLATE = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK
	} walk_state_t;

	typedef enum logic [0:0] {
		CFG_ROOT_PPN,
		CFG_TABLE_BASE_PPN
	} cfg_reg_t;

	typedef enum logic [1:0] {
		LVL_0,
		LVL_1,
		LVL_2
	} level_t;

	// physical address from a leaf entry, by the level it was found at
	function automatic logic [PA_W-1:0] leaf_pa(logic [PTE_W-1:0] pte,
			logic [VA_W-1:0] va, level_t lvl);
		logic [PA_W-1:0] pa;
		pa = '0;
		unique case (lvl)
			LVL_0: pa = {pte[53:10], va[11:0]};
			LVL_1: pa = {pte[53:19], va[20:0]};
			LVL_2: pa = {pte[53:28], va[29:0]};
			default: pa = '0;
		endcase
		return pa;
	endfunction

endpackage

`default_nettype wire

### rtl/core/sv39ptw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sv39ptw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/core/sv39ptw_locate.sv
`timescale 1ns / 1ps
`default_nettype none

module sv39ptw_locate import sv39ptw_pkg::*; #(
	parameter int TABLE_COUNT = 8
) (
	input  wire logic [PPN_W-1:0]                               ppn,
	input  wire logic [PPN_W-1:0]                               base_ppn,
	input  wire logic [VPN_W-1:0]                               vpn,
	output logic                                                hit,
	output logic      [$clog2(TABLE_COUNT*ENTRIES_PER_TABLE)-1:0] addr
);

	localparam int AW = $clog2(TABLE_COUNT * ENTRIES_PER_TABLE);

	logic [PPN_W-1:0]       off;
	logic [PPN_W+VPN_W-1:0] addr_full;

	// table number is the offset from the store base page
	assign off       = ppn - base_ppn;
	assign hit       = (ppn >= base_ppn) && (off < PPN_W'(TABLE_COUNT));
	assign addr_full = {off, vpn};
	assign addr      = addr_full[AW-1:0];

endmodule

`default_nettype wire

### rtl/core/sv39_page_table_walk.sv
// Sv39 page-table walker over a local store of TABLE_COUNT tables of 512
// 64-bit entries. After reset the store is swept to zero, one entry per
// cycle; busy stays high during the sweep while configuration writes are
// still taken. An item is taken when start is high and busy is low. A
// write item's result shows in the next cycle. A translate item reads one
// entry per level through the single read port of the store, whose read
// data arrives in the next cycle; it faults without a walk when the root
// table lies outside the store, and otherwise walks one level per entry
// read. Its result shows for one cycle on done, and the next item may be
// taken in that same cycle. The receiver cannot stall: done is high for
// exactly one cycle per item and must be captured then.
`timescale 1ns / 1ps
`default_nettype none

module sv39_page_table_walk import sv39ptw_pkg::*; #(
	parameter int TABLE_COUNT = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [0:0]        cfg_index,
	input  wire logic [PPN_W-1:0]  cfg_data,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              cmd,
	input  wire logic [IDX_W-1:0]  entry_index,
	input  wire logic [PTE_W-1:0]  entry_value,
	input  wire logic [VA_W-1:0]   vaddr,
	output logic                   done,
	output logic      [PA_W-1:0]   paddr,
	output logic                   fault
);

	localparam int DEPTH = TABLE_COUNT * ENTRIES_PER_TABLE;
	localparam int AW    = $clog2(DEPTH);

	walk_state_t      state_q, state_d;
	level_t           level_q, level_d;
	logic [AW-1:0]    clr_q;
	logic [PPN_W-1:0] root_ppn_q;
	logic [PPN_W-1:0] base_ppn_q;
	logic [VA_W-1:0]  va_q;
	logic             done_q;
	logic             fault_q;
	logic [PA_W-1:0]  paddr_q;

	logic             va_load;
	logic             res_load;
	logic             res_fault;
	logic [PA_W-1:0]  res_pa;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [PTE_W-1:0] mem_wdata;
	logic [AW-1:0]    mem_raddr;
	logic [PTE_W-1:0] mem_rdata;

	logic [PPN_W-1:0] loc_ppn;
	logic [VPN_W-1:0] loc_vpn;
	logic             loc_hit;

	logic [AW+IDX_W-1:0] wr_idx_ext;
	logic                wr_in_range;
	logic                pte_valid;
	logic                pte_leaf;

	assign wr_idx_ext  = (AW+IDX_W)'(entry_index);
	assign wr_in_range = 32'(entry_index) < 32'(DEPTH);
	assign pte_valid   = mem_rdata[0];
	assign pte_leaf    = |mem_rdata[3:1];

	sv39ptw_ram #(
		.WIDTH(PTE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	sv39ptw_locate #(
		.TABLE_COUNT(TABLE_COUNT)
	) u_locate (
		.ppn     (loc_ppn),
		.base_ppn(base_ppn_q),
		.vpn     (loc_vpn),
		.hit     (loc_hit),
		.addr    (mem_raddr)
	);

	always_comb begin
		state_d   = state_q;
		level_d   = level_q;
		va_load   = 1'b0;
		res_load  = 1'b0;
		res_fault = 1'b0;
		res_pa    = '0;
		mem_we    = 1'b0;
		mem_waddr = wr_idx_ext[AW-1:0];
		mem_wdata = entry_value;
		loc_ppn   = root_ppn_q;
		loc_vpn   = vaddr[38:30];
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (cmd == CMD_WRITE) begin
						mem_we   = wr_in_range;
						res_load = 1'b1;
					end else begin
						va_load = 1'b1;
						level_d = LVL_2;
						if (loc_hit) begin
							state_d = ST_WALK;
						end else begin
							res_load  = 1'b1;
							res_fault = 1'b1;
						end
					end
				end
			end
			ST_WALK: begin
				loc_ppn = mem_rdata[53:10];
				loc_vpn = (level_q == LVL_2) ? va_q[29:21] : va_q[20:12];
				priority if (!pte_valid) begin
					res_load  = 1'b1;
					res_fault = 1'b1;
					state_d   = ST_IDLE;
				end else if (pte_leaf) begin
					res_load = 1'b1;
					res_pa   = leaf_pa(mem_rdata, va_q, level_q);
					state_d  = ST_IDLE;
				end else if (level_q == LVL_0 || !loc_hit) begin
					res_load  = 1'b1;
					res_fault = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					level_d = (level_q == LVL_2) ? LVL_1 : LVL_0;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			level_q    <= LVL_2;
			clr_q      <= '0;
			done_q     <= 1'b0;
			root_ppn_q <= '0;
			base_ppn_q <= '0;
		end else begin
			state_q <= state_d;
			level_q <= level_d;
			done_q  <= res_load;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROOT_PPN:       root_ppn_q <= cfg_data;
					CFG_TABLE_BASE_PPN: base_ppn_q <= cfg_data;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (va_load) begin
			va_q <= vaddr;
		end
		if (res_load) begin
			fault_q <= res_fault;
			paddr_q <= res_pa;
		end
	end

	assign busy  = (state_q != ST_IDLE);
	assign done  = done_q;
	assign fault = fault_q;
	assign paddr = paddr_q;

endmodule

`default_nettype wire

### rtl/core/sv39ptw_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module sv39ptw_chk import sv39ptw_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire logic             cmd,
	input wire logic             done,
	input wire logic [PA_W-1:0]  paddr,
	input wire logic             fault
);

	// a write transfer answers in the next cycle with a clean result
	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == CMD_WRITE |=> done && !fault && paddr == '0)
		else $error("write transfer without clean result");

	// a translate transfer either walks or faults at once
	a_translate_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == CMD_TRANSLATE |=> busy || (done && fault))
		else $error("translate transfer neither walking nor faulting");

	a_fault_zero_pa: assert property (@(posedge clk) disable iff (!arst_n)
		done && fault |-> paddr == '0)
		else $error("faulting result with nonzero address");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while still walking");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result with no transfer behind it");

endmodule

bind sv39_page_table_walk sv39ptw_chk u_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.cmd   (cmd),
	.done  (done),
	.paddr (paddr),
	.fault (fault)
);

`default_nettype wire
